>>> hdl/lsbfr_pkg.sv
// Shared types and constants for the LSB-first bit field reader.
// Used by lsbfr_ctrl, lsbfr_datapath and lsb_first_bit_field_reader; no dependencies.
package lsbfr_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);
  localparam int MAX_FIELD_BITS = 32;
  localparam int FETCH_BYTES    = 5;
  localparam int CURSOR_W       = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2,
    OP_ALIGN = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_WIDTH     = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_PADDING   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_BYTE_COUNT    = 2'd0,
    REG_START_BIT     = 2'd1,
    REG_WINDOW_LENGTH = 2'd2,
    REG_LENGTH_TO_END = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [5:0]  read_width;
  } item_t;

  typedef struct packed {
    logic [31:0] field_value;
    logic [2:0]  status;
    logic [15:0] cursor;
    logic [15:0] bits_left;
    logic        on_byte_boundary;
    logic        window_ok;
  } result_t;

  typedef struct packed {
    logic take;
    logic issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_fetch;
    logic fetch_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/lsbfr_ctrl.sv
// Controller state machine of the bit field reader: accept, byte fetch and finish.
// Depends on lsbfr_pkg; drives commands into lsbfr_datapath.
module lsbfr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  lsbfr_pkg::dp_status_t  stat,
  output lsbfr_pkg::dp_cmd_t     cmd
);
  import lsbfr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = stat.need_fetch ? S_FETCH : S_FINISH;
        end
      end
      S_FETCH: begin
        cmd.issue = 1'b1;
        if (stat.fetch_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/lsbfr_datapath.sv
// Datapath of the bit field reader: byte store, window state, fetch buffer and result register.
// Depends on lsbfr_pkg; sequenced by lsbfr_ctrl.
module lsbfr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  lsbfr_pkg::item_t      item,
  output lsbfr_pkg::result_t    result,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  lsbfr_pkg::dp_cmd_t    cmd,
  output lsbfr_pkg::dp_status_t stat
);
  import lsbfr_pkg::*;

  logic [12:0]         byte_count;
  logic [15:0]         start_bit;
  logic [15:0]         window_length;
  logic                length_to_end;

  logic [CURSOR_W-1:0] cursor, cursor_next;
  logic [CURSOR_W-1:0] bit_end, bit_end_next;
  logic                window_valid, window_valid_next;
  logic [CURSOR_W-1:0] left;

  item_t               cur;
  logic [5:0]          eff_w;

  logic [7:0]          mem [BUFFER_BYTES];
  logic [7:0]          rdata;
  logic [ADDR_W-1:0]   rd_addr;
  logic [2:0]          fidx;
  logic [2:0]          rd_slot;
  logic                rd_pending;
  logic [7:0]          wbuf [FETCH_BYTES];

  logic [2:0]          off;
  logic [5:0]          pad;
  logic [5:0]          in_eff;
  logic [6:0]          span;
  logic [2:0]          nbytes;

  logic [8*FETCH_BYTES-1:0] word;
  logic [8*FETCH_BYTES-1:0] shifted;
  logic [MAX_FIELD_BITS:0]  mask;
  logic [31:0]              extract;

  logic [12:0]         bytes_used;
  logic [15:0]         avail;
  logic [15:0]         rem;
  logic [15:0]         len;

  result_t             res_next;
  logic [2:0]          st_next;
  logic [31:0]         val_next;

  assign left   = window_valid ? bit_end - cursor : '0;
  assign off    = cursor[2:0];
  assign pad    = {3'b000, 3'(3'd0 - off)};
  assign in_eff = (op_e'(item.operation) == OP_ALIGN) ? pad : item.read_width;

  assign stat.need_fetch = window_valid
                        && (op_e'(item.operation) == OP_READ || op_e'(item.operation) == OP_ALIGN)
                        && (in_eff != 6'd0)
                        && (in_eff <= 6'(MAX_FIELD_BITS))
                        && ({10'b0, in_eff} <= left);

  assign span            = 7'(off) + 7'(eff_w) + 7'd7;
  assign nbytes          = 3'(span >> 3);
  assign stat.fetch_last = (fidx == nbytes - 3'd1);
  assign stat.out_free   = !result_valid || result_ready;

  assign rd_addr = ADDR_W'(cursor[CURSOR_W-1:3]) + ADDR_W'(fidx);

  always_ff @(posedge clk) begin
    if (cmd.take && op_e'(item.operation) == OP_LOAD) begin
      mem[item.load_address] <= item.load_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur   <= item;
      eff_w <= in_eff;
    end
    if (cmd.issue) begin
      rd_slot <= fidx;
    end
    if (rd_pending) begin
      wbuf[rd_slot] <= rdata;
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fidx       <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.issue;
      if (cmd.take) begin
        fidx <= '0;
      end else if (cmd.issue) begin
        fidx <= fidx + 3'd1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < FETCH_BYTES; k++) begin
      word[8*k +: 8] = wbuf[k];
    end
  end

  assign shifted = word >> off;
  assign mask    = ((MAX_FIELD_BITS+1)'(1) << eff_w) - (MAX_FIELD_BITS+1)'(1);
  assign extract = shifted[31:0] & mask[31:0];

  assign bytes_used = (byte_count > 13'(BUFFER_BYTES)) ? 13'(BUFFER_BYTES) : byte_count;
  assign avail      = {bytes_used, 3'b000};
  assign rem        = avail - start_bit;
  assign len        = length_to_end ? rem : window_length;

  always_comb begin
    st_next           = ST_OK;
    val_next          = '0;
    cursor_next       = cursor;
    bit_end_next      = bit_end;
    window_valid_next = window_valid;
    unique case (op_e'(cur.operation))
      OP_LOAD: begin
        st_next = ST_OK;
      end
      OP_START: begin
        if (start_bit > avail || len > rem) begin
          window_valid_next = 1'b0;
          cursor_next       = '0;
          bit_end_next      = '0;
          st_next           = ST_INVALID;
        end else begin
          window_valid_next = 1'b1;
          cursor_next       = start_bit;
          bit_end_next      = start_bit + len;
        end
      end
      OP_READ: begin
        priority if (!window_valid) begin
          st_next = ST_INVALID;
        end else if (cur.read_width > 6'(MAX_FIELD_BITS)) begin
          st_next = ST_WIDTH;
        end else if ({10'b0, cur.read_width} > left) begin
          st_next = ST_TRUNCATED;
        end else begin
          val_next    = extract;
          cursor_next = cursor + CURSOR_W'(cur.read_width);
        end
      end
      OP_ALIGN: begin
        priority if (!window_valid) begin
          st_next = ST_INVALID;
        end else if (eff_w == 6'd0) begin
          st_next = ST_OK;
        end else if ({10'b0, eff_w} > left) begin
          st_next = ST_TRUNCATED;
        end else if (extract != 32'd0) begin
          st_next = ST_PADDING;
        end else begin
          cursor_next = cursor + CURSOR_W'(eff_w);
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase

    res_next.field_value      = val_next;
    res_next.status           = st_next;
    res_next.cursor           = cursor_next;
    res_next.bits_left        = window_valid_next ? bit_end_next - cursor_next : '0;
    res_next.on_byte_boundary = window_valid_next && (cursor_next[2:0] == 3'd0);
    res_next.window_ok        = window_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      start_bit     <= '0;
      window_length <= '0;
      length_to_end <= 1'b1;
      cursor        <= '0;
      bit_end       <= '0;
      window_valid  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_e'(cfg_index))
          REG_BYTE_COUNT:    byte_count    <= cfg_data[12:0];
          REG_START_BIT:     start_bit     <= cfg_data;
          REG_WINDOW_LENGTH: window_length <= cfg_data;
          REG_LENGTH_TO_END: length_to_end <= cfg_data[0];
          default:           length_to_end <= length_to_end;
        endcase
      end
      if (cmd.finish) begin
        cursor       <= cursor_next;
        bit_end      <= bit_end_next;
        window_valid <= window_valid_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_closed_window_zero: assert property (@(posedge clk) disable iff (rst)
    !window_valid |-> (cursor == '0 && bit_end == '0))
    else $error("Closed window holds a nonzero cursor or end.");

  a_cursor_in_window: assert property (@(posedge clk) disable iff (rst)
    window_valid |-> cursor <= bit_end)
    else $error("Cursor has passed the end of the window.");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> fidx < 3'(FETCH_BYTES))
    else $error("Byte fetch runs beyond the fetch buffer.");

  a_read_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && op_e'(cur.operation) == OP_READ && st_next == ST_OK)
    |=> cursor == $past(cursor) + CURSOR_W'($past(cur.read_width)))
    else $error("Successful read did not advance the cursor by its width.");

  a_boundary_flag: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.on_byte_boundary) |-> (result.window_ok && result.cursor[2:0] == 3'd0))
    else $error("Byte boundary flag set off a boundary or without a window.");

endmodule

>>> hdl/lsb_first_bit_field_reader.sv
// Top level of the LSB-first bit field reader: controller and datapath joined by commands.
// Depends on lsbfr_pkg, lsbfr_ctrl and lsbfr_datapath.
//
//   Channel   Direction  Handshake                Payload
//   item      in         item_valid / item_ready  item (lsbfr_pkg::item_t)
//   result    out        result_valid/result_ready result (lsbfr_pkg::result_t)
//   cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Load, start, failed reads and zero-width reads go from idle straight to finish, with no byte fetch.
// A read or align that fetches n bytes, n being up to five, issues them one by one through the
// single read port of the byte store, then passes through a wait state before it finishes.
// Reset is synchronous; the byte store is not cleared and holds no data until loaded.
// A new item is taken while a result waits in the output register; the block only stalls
// at the end of the next item if that result has still not been taken.
module lsb_first_bit_field_reader (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  lsbfr_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output lsbfr_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lsbfr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  lsbfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lsbfr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for lsb_first_bit_field_reader: a scoreboard class predicts each
// result beat from the accepted item beats, while plain tasks drive the item and cfg channels.
// Depends on lsbfr_pkg and the lsb_first_bit_field_reader RTL.
`timescale 1ns / 1ps

module testbench;
  import lsbfr_pkg::*;

  class reader_scoreboard;
    logic [7:0]  store [BUFFER_BYTES];
    bit          loaded [BUFFER_BYTES];
    int unsigned cursor;
    int unsigned bit_end;
    bit          window_valid;
    int unsigned byte_count;
    int unsigned start_bit;
    int unsigned window_length;
    bit          to_end;
    result_t     expected_results [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen [5];

    function new();
      to_end = 1'b1;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        REG_BYTE_COUNT:    byte_count = data[12:0];
        REG_START_BIT:     start_bit = data;
        REG_WINDOW_LENGTH: window_length = data;
        default:           to_end = data[0];
      endcase
    endfunction

    function int unsigned bits_left();
      return window_valid ? bit_end - cursor : 0;
    endfunction

    function void open_window();
      int unsigned avail;
      int unsigned rem;
      int unsigned len;
      avail = (byte_count > BUFFER_BYTES ? BUFFER_BYTES : byte_count) * 8;
      window_valid = 1'b0;
      cursor = 0;
      bit_end = 0;
      if (start_bit <= avail) begin
        rem = avail - start_bit;
        len = to_end ? rem : window_length;
        if (len <= rem) begin
          cursor = start_bit;
          bit_end = start_bit + len;
          window_valid = 1'b1;
        end
      end
    endfunction

    function status_e take_bits(int unsigned width, output logic [31:0] value);
      int unsigned pos;
      value = '0;
      if (!window_valid) return ST_INVALID;
      if (width > MAX_FIELD_BITS) return ST_WIDTH;
      if (width > bits_left()) return ST_TRUNCATED;
      for (int unsigned i = 0; i < width; i++) begin
        pos = cursor + i;
        value[i] = store[pos >> 3][pos & 7];
      end
      cursor += width;
      return ST_OK;
    endfunction

    // Bytes that an item would read from the store, so that unloaded ones can be filled first.
    function bit touches_bytes(item_t it, output int unsigned first, output int unsigned last);
      int unsigned pad;
      first = 0;
      last = 0;
      if (!window_valid) return 1'b0;
      if (it.operation == OP_READ) begin
        if (it.read_width == 0 || it.read_width > MAX_FIELD_BITS || it.read_width > bits_left())
          return 1'b0;
        first = cursor >> 3;
        last = (cursor + it.read_width - 1) >> 3;
        return 1'b1;
      end
      if (it.operation == OP_ALIGN) begin
        pad = (8 - (cursor & 7)) & 7;
        if (pad == 0 || pad > bits_left()) return 1'b0;
        first = cursor >> 3;
        last = first;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void predict_item(item_t it);
      result_t     want;
      logic [31:0] value;
      logic [31:0] padding;
      status_e     st;
      int unsigned pad;
      value = '0;
      st = ST_OK;
      case (op_e'(it.operation))
        OP_LOAD: begin
          store[it.load_address] = it.load_data;
          loaded[it.load_address] = 1'b1;
        end
        OP_START: begin
          open_window();
          st = window_valid ? ST_OK : ST_INVALID;
        end
        OP_READ: begin
          st = take_bits(it.read_width, value);
          if (st != ST_OK) value = '0;
        end
        default: begin
          if (!window_valid) begin
            st = ST_INVALID;
          end else begin
            pad = (8 - (cursor & 7)) & 7;
            if (pad != 0) begin
              st = take_bits(pad, padding);
              if (st == ST_OK && padding != 0) begin
                cursor -= pad;
                st = ST_PADDING;
              end
            end
          end
        end
      endcase
      want.field_value = value;
      want.status = st;
      want.cursor = 16'(cursor);
      want.bits_left = 16'(bits_left());
      want.on_byte_boundary = window_valid && ((cursor & 7) == 0);
      want.window_ok = window_valid;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.status < 5) status_seen[want.status]++;
      compare_field("field_value", want.field_value, got.field_value);
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("cursor", 32'(want.cursor), 32'(got.cursor));
      compare_field("bits_left", 32'(want.bits_left), 32'(got.bits_left));
      compare_field("on_byte_boundary", 32'(want.on_byte_boundary), 32'(got.on_byte_boundary));
      compare_field("window_ok", 32'(want.window_ok), 32'(got.window_ok));
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 16;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  reader_scoreboard board;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned settings_written;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  bit          quiet;

  lsb_first_bit_field_reader dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_result(result);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  function automatic item_t make_item(op_e op, int unsigned addr, int unsigned data,
                                      int unsigned width);
    item_t it;
    it.operation = op;
    it.load_address = 12'(addr);
    it.load_data = 8'(data);
    it.read_width = 6'(width);
    return it;
  endfunction

  function automatic int unsigned fill_byte();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    board.predict_item(it);
    items_sent++;
  endtask

  task automatic issue(item_t it);
    int unsigned first;
    int unsigned last;
    if (board.touches_bytes(it, first, last)) begin
      for (int unsigned a = first; a <= last; a++) begin
        if (!board.loaded[a])
          send_item(make_item(OP_LOAD, a, fill_byte(), $urandom_range(0, 63)));
      end
    end
    send_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
  endtask

  task automatic write_settings(int unsigned bc, int unsigned sbit, int unsigned wlen, bit lte);
    logic [15:0] vals [4];
    vals[0] = {3'($urandom_range(0, 7)), 13'(bc)};
    vals[1] = 16'(sbit);
    vals[2] = 16'(wlen);
    vals[3] = {15'($urandom_range(0, 32767)), lte};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic pick_settings();
    int unsigned bc;
    int unsigned avail;
    int unsigned sbit;
    int unsigned wlen;
    int unsigned rem;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)      bc = $urandom_range(1, 16);
    else if (r < 73) bc = 0;
    else if (r < 83) bc = BUFFER_BYTES;
    else if (r < 90) bc = $urandom_range(BUFFER_BYTES + 1, 8191);
    else             bc = $urandom_range(17, BUFFER_BYTES - 1);
    avail = (bc > BUFFER_BYTES ? BUFFER_BYTES : bc) * 8;
    r = $urandom_range(0, 99);
    if (r < 10)      sbit = $urandom_range(avail + 1, 65535);
    else if (r < 20) sbit = avail;
    else if (r < 30) sbit = 0;
    else if (r < 55) sbit = $urandom_range(avail > 120 ? avail - 120 : 0, avail);
    else             sbit = $urandom_range(0, avail);
    rem = sbit <= avail ? avail - sbit : 0;
    r = $urandom_range(0, 99);
    if (r < 50)      wlen = $urandom_range(0, rem > 160 ? 160 : rem);
    else if (r < 65) wlen = rem;
    else if (r < 80) wlen = $urandom_range(0, 65535);
    else             wlen = rem + $urandom_range(1, 8);
    write_settings(bc, sbit, wlen, $urandom_range(0, 1));
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned r;
    int unsigned left;
    left = board.bits_left();
    it = make_item(OP_READ, $urandom_range(0, 4095), fill_byte(), $urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it.operation = OP_LOAD;
    end else if (r < 18 || (left == 0 && r < 40)) begin
      it.operation = OP_START;
    end else if (r < 33) begin
      it.operation = OP_ALIGN;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60)      it.read_width = 6'($urandom_range(0, left > 32 ? 32 : left));
      else if (r < 75) it.read_width = 6'($urandom_range(0, 32));
      else if (r < 85) it.read_width = 6'($urandom_range(33, 63));
      else if (left <= 62) it.read_width = 6'(left + $urandom_range(0, 1));
    end
    return it;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned random_from;
    int unsigned count;
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BYTE_COUNT;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // After reset the window is invalid; a start with no data opens an empty window.
    issue(make_item(OP_READ, 0, 0, 5));
    issue(make_item(OP_ALIGN, 0, 0, 0));
    issue(make_item(OP_START, 0, 0, 0));
    issue(make_item(OP_READ, 0, 0, 0));
    issue(make_item(OP_READ, 0, 0, 1));
    issue(make_item(OP_ALIGN, 0, 0, 0));
    drain();
    write_settings(6, 3, 40, 1'b0);
    issue(make_item(OP_LOAD, 0, 8'h5A, 0));
    issue(make_item(OP_LOAD, 1, 8'h00, 0));
    issue(make_item(OP_LOAD, 2, 8'h01, 0));
    issue(make_item(OP_LOAD, 3, 8'h80, 0));
    issue(make_item(OP_LOAD, 4, 8'hFF, 0));
    issue(make_item(OP_LOAD, 5, 8'hC3, 0));
    issue(make_item(OP_LOAD, BUFFER_BYTES - 1, 8'hFF, 63));
    issue(make_item(OP_LOAD, 2048, 8'h00, 0));
    issue(make_item(OP_START, 0, 0, 0));
    issue(make_item(OP_ALIGN, 0, 0, 0));
    issue(make_item(OP_READ, 0, 0, 5));
    issue(make_item(OP_ALIGN, 0, 0, 0));
    issue(make_item(OP_READ, 0, 0, 9));
    issue(make_item(OP_ALIGN, 0, 0, 0));
    issue(make_item(OP_READ, 0, 0, 16));
    issue(make_item(OP_READ, 0, 0, 33));
    issue(make_item(OP_READ, 0, 0, 4));
    issue(make_item(OP_READ, 0, 0, 3));
    issue(make_item(OP_ALIGN, 0, 0, 0));

    random_from = items_sent;
    phase = 0;
    while (items_sent - random_from < RANDOM_ITEMS) begin
      drain();
      quiet = (phase >= 8 && phase < 14);
      pick_settings();
      if (phase == 3) hold_requests++;
      issue(make_item(OP_START, $urandom_range(0, 4095), $urandom_range(0, 255),
                      $urandom_range(0, 63)));
      count = $urandom_range(20, 60);
      for (int unsigned i = 0; i < count; i++) issue(random_item());
      phase++;
    end

    drain();
    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    board.errors += board.expected_results.size();
    $display("Sent %0d item beats under %0d register settings; checked %0d result beats.",
             items_sent, settings_written, board.checked);
    $display("Statuses seen: ok %0d, invalid %0d, width %0d, truncated %0d, padding %0d.",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4]);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/lsbfr_pkg.sv
hdl/lsbfr_ctrl.sv
hdl/lsbfr_datapath.sv
hdl/lsb_first_bit_field_reader.sv
tb/testbench.sv
